// ===== src/dmmc_pkg.sv =====
`timescale 1ns / 1ps

package dmmc_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULSE,
    ST_NEG,
    ST_CLASS,
    ST_SEND
  } state_e;

  // Configuration register indexes.
  localparam logic [2:0] CfgLeftAddr  = 3'd0;
  localparam logic [2:0] CfgRightAddr = 3'd1;
  localparam logic [2:0] CfgSpeedLim  = 3'd2;
  localparam logic [2:0] CfgDeadband  = 3'd3;
  localparam logic [2:0] CfgToggleThr = 3'd4;

  localparam logic [7:0]  LeftAddrRst  = 8'd100;
  localparam logic [7:0]  RightAddrRst = 8'd101;
  localparam logic [14:0] SpeedLimRst  = 15'd2950;
  localparam logic [14:0] DeadbandRst  = 15'd100;
  localparam logic [15:0] ToggleThrRst = 16'd800;
  localparam logic [15:0] PulseRst     = 16'd1500;

  // Motor drive commands.
  localparam logic [3:0] CmdForward = 4'd1;
  localparam logic [3:0] CmdReverse = 4'd2;
  localparam logic [3:0] CmdFree    = 4'd6;
  localparam logic [3:0] CmdBrake   = 4'd9;

  // Frame layout constants.
  localparam logic [7:0]  FuncWriteMulti = 8'h10;
  localparam logic [15:0] StartReg       = 16'h2000;
  localparam logic [15:0] RegCount       = 16'h0002;
  localparam logic [7:0]  ByteCount      = 8'h04;
  localparam logic [3:0]  CrcLastPos     = 4'd10;
  localparam logic [3:0]  LastPos        = 4'd12;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // One byte through the reflected Modbus CRC16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Byte at a given position of the request frame.
  function automatic logic [7:0] frame_byte(input logic [3:0] pos, input logic [7:0] addr,
                                            input logic [3:0] cmd, input logic [15:0] val,
                                            input logic [15:0] crc);
    logic [7:0] b;
    case (pos)
      4'd0:    b = addr;
      4'd1:    b = FuncWriteMulti;
      4'd2:    b = StartReg[15:8];
      4'd3:    b = StartReg[7:0];
      4'd4:    b = RegCount[15:8];
      4'd5:    b = RegCount[7:0];
      4'd6:    b = ByteCount;
      4'd7:    b = 8'h00;
      4'd8:    b = {4'h0, cmd};
      4'd9:    b = val[15:8];
      4'd10:   b = val[7:0];
      4'd11:   b = crc[7:0];
      4'd12:   b = crc[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/dual_motor_modbus_commander_core.sv =====
`timescale 1ns / 1ps

// Dual motor Modbus commander. Each accepted word carries both speed demands and the
// stop-button pulse width; the block serves the left and right drive in turn and emits
// one 13-byte Modbus RTU write-multiple-registers request for the served drive, one byte
// per output word, with tlast on the final CRC byte. A served speed whose magnitude equals
// the deadband produces no frame. An item goes through evaluation (pulse check and clamp,
// sign, command decision) and then the frame is sent, one byte per cycle while the output
// register is free, the CRC being updated as each byte is registered. With no frame the
// block returns to idle after the command decision. The input is not ready until the
// current frame has been handed to the output register. The user must write the
// configuration through the plain write port while idle; the block does not enforce this.
module dual_motor_modbus_commander_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_wr_en_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Command stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // left_speed, right_speed, button_pulse
  // Frame byte stream out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // frame_byte
  output logic        m_axis_tlast   // frame_end
);

  // Configuration registers.
  logic [7:0]  left_addr_q, right_addr_q;
  logic [14:0] speed_lim_q, deadband_q;
  logic [15:0] toggle_thr_q;

  // Control state.
  dmmc_pkg::state_e state_q, state_d;
  logic        brake_q, brake_d;
  logic [15:0] prev_pulse_q, prev_pulse_d;
  logic        serve_right_q, serve_right_d;
  logic [15:0] crc_q, crc_d;
  logic [3:0]  pos_q, pos_d;
  logic        out_valid_q, out_valid_d;

  // Item payload.
  logic signed [16:0] spd_q, spd_d;
  logic [15:0] pulse_q, pulse_d;
  logic [7:0]  addr_q, addr_d;
  logic        right_q, right_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [15:0] val_q, val_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;

  logic               in_fire;
  logic               slot_free;
  logic [16:0]        pulse_diff;
  logic [16:0]        pulse_abs;
  logic signed [16:0] lim_s, db_s;
  logic signed [16:0] spd_neg;
  logic [7:0]         cur_byte;

  assign s_axis_tready = (state_q == dmmc_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  assign pulse_diff = {1'b0, pulse_q} - {1'b0, prev_pulse_q};
  assign pulse_abs  = pulse_diff[16] ? (17'd0 - pulse_diff) : pulse_diff;
  assign lim_s      = $signed({2'b00, speed_lim_q});
  assign db_s       = $signed({2'b00, deadband_q});
  assign spd_neg    = 17'sd0 - spd_q;
  assign cur_byte   = dmmc_pkg::frame_byte(pos_q, addr_q, cmd_q, val_q, crc_q);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_addr_q  <= dmmc_pkg::LeftAddrRst;
      right_addr_q <= dmmc_pkg::RightAddrRst;
      speed_lim_q  <= dmmc_pkg::SpeedLimRst;
      deadband_q   <= dmmc_pkg::DeadbandRst;
      toggle_thr_q <= dmmc_pkg::ToggleThrRst;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        dmmc_pkg::CfgLeftAddr:  left_addr_q  <= cfg_wdata_i[7:0];
        dmmc_pkg::CfgRightAddr: right_addr_q <= cfg_wdata_i[7:0];
        dmmc_pkg::CfgSpeedLim:  speed_lim_q  <= cfg_wdata_i[14:0];
        dmmc_pkg::CfgDeadband:  deadband_q   <= cfg_wdata_i[14:0];
        dmmc_pkg::CfgToggleThr: toggle_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dmmc_pkg::ST_IDLE;
      brake_q       <= 1'b0;
      prev_pulse_q  <= dmmc_pkg::PulseRst;
      serve_right_q <= 1'b0;
      crc_q         <= dmmc_pkg::CrcInit;
      pos_q         <= 4'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      brake_q       <= brake_d;
      prev_pulse_q  <= prev_pulse_d;
      serve_right_q <= serve_right_d;
      crc_q         <= crc_d;
      pos_q         <= pos_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_q      <= spd_d;
    pulse_q    <= pulse_d;
    addr_q     <= addr_d;
    right_q    <= right_d;
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    state_d       = state_q;
    brake_d       = brake_q;
    prev_pulse_d  = prev_pulse_q;
    serve_right_d = serve_right_q;
    crc_d         = crc_q;
    pos_d         = pos_q;
    out_valid_d   = out_valid_q;
    spd_d         = spd_q;
    pulse_d       = pulse_q;
    addr_d        = addr_q;
    right_d       = right_q;
    cmd_d         = cmd_q;
    val_d         = val_q;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dmmc_pkg::ST_IDLE: begin
        if (in_fire) begin
          pulse_d       = s_axis_tdata[47:32];
          right_d       = serve_right_q;
          serve_right_d = !serve_right_q;
          if (serve_right_q) begin
            spd_d  = $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
            addr_d = right_addr_q;
          end else begin
            spd_d  = $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
            addr_d = left_addr_q;
          end
          state_d = dmmc_pkg::ST_PULSE;
        end
      end
      dmmc_pkg::ST_PULSE: begin
        if (pulse_abs > {1'b0, toggle_thr_q}) begin
          brake_d = !brake_q;
        end
        prev_pulse_d = pulse_q;
        if (spd_q > lim_s) begin
          spd_d = lim_s;
        end else if (spd_q < -lim_s) begin
          spd_d = -lim_s;
        end
        state_d = dmmc_pkg::ST_NEG;
      end
      dmmc_pkg::ST_NEG: begin
        if (right_q) begin
          spd_d = spd_neg;
        end
        state_d = dmmc_pkg::ST_CLASS;
      end
      dmmc_pkg::ST_CLASS: begin
        crc_d = dmmc_pkg::CrcInit;
        pos_d = 4'd0;
        state_d = dmmc_pkg::ST_SEND;
        if (spd_q > db_s) begin
          cmd_d = dmmc_pkg::CmdReverse;
          val_d = spd_q[15:0];
        end else if (spd_q < -db_s) begin
          cmd_d = dmmc_pkg::CmdForward;
          val_d = spd_neg[15:0];
        end else if (spd_q < db_s && spd_q > -db_s) begin
          cmd_d = brake_q ? dmmc_pkg::CmdBrake : dmmc_pkg::CmdFree;
          val_d = 16'd0;
        end else begin
          // Magnitude exactly at the deadband: the turn is used up without a frame.
          state_d = dmmc_pkg::ST_IDLE;
        end
      end
      dmmc_pkg::ST_SEND: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = cur_byte;
          out_last_d  = (pos_q == dmmc_pkg::LastPos);
          if (pos_q <= dmmc_pkg::CrcLastPos) begin
            crc_d = dmmc_pkg::crc16_byte(crc_q, cur_byte);
          end
          if (pos_q == dmmc_pkg::LastPos) begin
            crc_d   = dmmc_pkg::CrcInit;
            pos_d   = 4'd0;
            state_d = dmmc_pkg::ST_IDLE;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = dmmc_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= dmmc_pkg::LastPos)
    else $error("frame byte position out of range");

  a_crc_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmmc_pkg::ST_SEND && pos_q == 4'd0) |-> crc_q == dmmc_pkg::CrcInit)
    else $error("CRC not at its initial value at frame start");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == dmmc_pkg::ST_PULSE)
    else $error("accepted word did not start evaluation");

  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmmc_pkg::ST_SEND && slot_free && pos_q == dmmc_pkg::LastPos)
    |=> (state_q == dmmc_pkg::ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("last frame byte not marked or sequencer not back to idle");

endmodule
